/* sv/cft_pkg.sv */
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

   localparam int PEND_DEPTH_DEF = 4;

   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   localparam logic [7:0]  DELIM_RST      = 8'd44;
   localparam logic [7:0]  QUOTE_RST      = 8'd34;
   localparam logic [6:0]  MAX_FIELDS_RST = 7'd32;
   localparam logic [13:0] MAX_LEN_RST    = 14'd8192;

   localparam logic [6:0] FIELD_CNT_MAX = 7'd127;
   localparam logic [5:0] FIELD_IDX_MAX = 6'd63;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_LAST = 2'd2;

   // quote modes; the unused code behaves as plain
   localparam logic [1:0] QM_PLAIN  = 2'd0;
   localparam logic [1:0] QM_QUOTED = 2'd1;
   localparam logic [1:0] QM_QSEEN  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DELIM      = 2'd0;
   localparam logic [1:0] CSR_QUOTE      = 2'd1;
   localparam logic [1:0] CSR_MAX_FIELDS = 2'd2;
   localparam logic [1:0] CSR_MAX_LEN    = 2'd3;

   typedef struct packed {
      logic [7:0]  delimiter;
      logic [7:0]  quote_byte;
      logic [6:0]  fld_limit;
      logic [13:0] len_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  quote_mode;
      logic [6:0]  fld_cnt;
      logic [13:0] field_length;
      logic        truncated;
   } tok_state_type;

   // field ends that follow the content run of one word
   typedef struct packed {
      logic       end_field;
      logic [5:0] index_a;
      logic       many_a;
      logic       trunc_a;
      logic       end_line;
      logic [5:0] index_b;
      logic       many_b;
      logic       trunc_b;
   } batch_meta_type;

endpackage

/* sv/csv_field_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core: splits a byte stream into CSV fields.
// A word passes the input register, then the result register. One word per
// cycle enters while results drain; a word giving more than one result holds
// the input while they drain, one result per cycle when rsp_stall is low.
// Sync reset clears config to defaults, state and pend count; pend bytes not.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core
   import cft_pkg::*;
#(
   parameter int PEND_DEPTH = PEND_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_field_index,
   output logic        rsp_field_truncated,
   output logic        rsp_too_many_fields,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_write_data
);

   localparam int PC_W = $clog2(PEND_DEPTH + 1);
   localparam int M_W  = $clog2(PEND_DEPTH + 2);

   cfg_type                    cfg_ff, cfg_in;
   tok_state_type              state_ff, state_in, state_nxt;
   logic [PEND_DEPTH-1:0][7:0] pend_ff, pend_in, pend_nxt;
   logic [PC_W-1:0]            pend_count_ff, pend_count_in, pend_count_nxt;
   logic                       item_valid_ff, item_valid_in;
   logic [7:0]                 item_byte_ff, item_byte_in;
   logic                       item_eol_ff, item_eol_in;
   logic [PEND_DEPTH:0][7:0]   content;
   logic [M_W-1:0]             content_count;
   batch_meta_type             meta;
   logic                       emit_free;
   logic                       advance;
   logic                       req_take;

   cft_step #(
      .PEND_DEPTH (PEND_DEPTH)
   ) u_step (
      .data_byte      (item_byte_ff),
      .last_in_line   (item_eol_ff),
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .pend           (pend_ff),
      .pend_count     (pend_count_ff),
      .nxt            (state_nxt),
      .pend_nxt       (pend_nxt),
      .pend_count_nxt (pend_count_nxt),
      .content        (content),
      .content_count  (content_count),
      .meta           (meta)
   );

   cft_emit #(
      .PEND_DEPTH (PEND_DEPTH)
   ) u_emit (
      .clock               (clock),
      .reset               (reset),
      .load                (advance),
      .content             (content),
      .content_count       (content_count),
      .meta                (meta),
      .free                (emit_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_kind            (rsp_kind),
      .rsp_field_index     (rsp_field_index),
      .rsp_field_truncated (rsp_field_truncated),
      .rsp_too_many_fields (rsp_too_many_fields),
      .rsp_last            (rsp_last)
   );

   always_comb begin
      advance   = item_valid_ff && emit_free;
      req_stall = item_valid_ff && !emit_free;
      req_take  = req_valid && !req_stall;

      item_valid_in = req_take || (item_valid_ff && !advance);
      item_byte_in  = req_take ? req_data_byte : item_byte_ff;
      item_eol_in   = req_take ? req_last_in_line : item_eol_ff;

      state_in      = advance ? state_nxt : state_ff;
      pend_in       = advance ? pend_nxt : pend_ff;
      pend_count_in = advance ? pend_count_nxt : pend_count_ff;

      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DELIM:      cfg_in.delimiter  = csr_write_data[7:0];
            CSR_QUOTE:      cfg_in.quote_byte = csr_write_data[7:0];
            CSR_MAX_FIELDS: cfg_in.fld_limit  = csr_write_data[6:0];
            CSR_MAX_LEN:    cfg_in.len_limit  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_eol_ff  <= item_eol_in;
      pend_ff      <= pend_in;
      if (reset) begin
         item_valid_ff         <= 1'b0;
         state_ff              <= '0;
         pend_count_ff         <= '0;
         cfg_ff.delimiter      <= DELIM_RST;
         cfg_ff.quote_byte     <= QUOTE_RST;
         cfg_ff.fld_limit      <= MAX_FIELDS_RST;
         cfg_ff.len_limit      <= MAX_LEN_RST;
      end else begin
         item_valid_ff <= item_valid_in;
         state_ff      <= state_in;
         pend_count_ff <= pend_count_in;
         cfg_ff        <= cfg_in;
      end
   end

endmodule

/* sv/cft_step.sv */
// ----------------------------------------------------------------------------
// cft_step
// Per-word tokenizer decision: next state, content run and field ends.
// ----------------------------------------------------------------------------
module cft_step
   import cft_pkg::*;
#(
   parameter int PEND_DEPTH = PEND_DEPTH_DEF,
   localparam int PC_W = $clog2(PEND_DEPTH + 1),
   localparam int M_W = $clog2(PEND_DEPTH + 2)
) (
   input  logic [7:0]                  data_byte,
   input  logic                        last_in_line,
   input  cfg_type                     cfg,
   input  tok_state_type               cur,
   input  logic [PEND_DEPTH-1:0][7:0]  pend,
   input  logic [PC_W-1:0]             pend_count,
   output tok_state_type               nxt,
   output logic [PEND_DEPTH-1:0][7:0]  pend_nxt,
   output logic [PC_W-1:0]             pend_count_nxt,
   output logic [PEND_DEPTH:0][7:0]    content,
   output logic [M_W-1:0]              content_count,
   output batch_meta_type              meta
);

   function automatic logic [5:0] sat_index(input logic [6:0] cnt);
      return (cnt > 7'(FIELD_IDX_MAX)) ? FIELD_IDX_MAX : cnt[5:0];
   endfunction

   logic             is_quote;
   logic             is_delim;
   logic             is_nl;
   logic             take;
   logic             delim_end;
   logic             flush;
   logic             push;
   logic             full;
   logic [1:0]       qmode_n;
   logic [M_W-1:0]   src_len;
   logic [13:0]      limit;
   logic [13:0]      room;
   logic [13:0]      len_mid;
   logic             trunc_mid;
   logic [6:0]       count_mid;

   always_comb begin
      is_quote  = data_byte == cfg.quote_byte;
      is_delim  = data_byte == cfg.delimiter;
      is_nl     = (data_byte == BYTE_CR) || (data_byte == BYTE_LF);
      take      = 1'b0;
      delim_end = 1'b0;
      qmode_n   = cur.quote_mode;

      priority if (cur.quote_mode == QM_QSEEN && is_quote) begin
         take    = 1'b1;
         qmode_n = QM_QUOTED;
      end else if (cur.quote_mode == QM_QUOTED) begin
         if (is_quote) begin
            qmode_n = QM_QSEEN;
         end else begin
            take = 1'b1;
         end
      end else begin
         priority if (is_quote) begin
            qmode_n = QM_QUOTED;
         end else if (is_delim) begin
            qmode_n   = QM_PLAIN;
            delim_end = 1'b1;
         end else begin
            qmode_n = QM_PLAIN;
            take    = 1'b1;
         end
      end

      flush = delim_end || (take && !is_nl);
      push  = take && is_nl;
      full  = pend_count >= PC_W'(PEND_DEPTH);

      // content run: pending bytes in order, then the word's own byte
      for (int i = 0; i < PEND_DEPTH; i++) begin
         content[i] = (PC_W'(i) < pend_count) ? pend[i] : data_byte;
      end
      content[PEND_DEPTH] = data_byte;

      priority if (flush) begin
         src_len = M_W'(pend_count) + M_W'(take && !is_nl);
      end else if (push && full) begin
         src_len = M_W'(1);
      end else begin
         src_len = '0;
      end

      limit = (cfg.len_limit == '0) ? '0 : cfg.len_limit - 14'd1;
      room  = (limit > cur.field_length) ? limit - cur.field_length : '0;
      if (room < 14'(src_len)) begin
         content_count = M_W'(room);
         trunc_mid     = 1'b1;
      end else begin
         content_count = src_len;
         trunc_mid     = cur.truncated;
      end
      len_mid   = cur.field_length + 14'(content_count);
      count_mid = (delim_end && cur.fld_cnt != FIELD_CNT_MAX) ?
                  cur.fld_cnt + 7'd1 : cur.fld_cnt;

      meta.end_field = delim_end;
      meta.index_a   = sat_index(cur.fld_cnt);
      meta.many_a    = cur.fld_cnt >= cfg.fld_limit;
      meta.trunc_a   = trunc_mid;
      meta.end_line  = last_in_line;
      meta.index_b   = sat_index(count_mid);
      meta.many_b    = count_mid >= cfg.fld_limit;
      meta.trunc_b   = delim_end ? 1'b0 : trunc_mid;

      pend_nxt       = pend;
      pend_count_nxt = pend_count;
      if (flush) begin
         pend_count_nxt = '0;
      end else if (push) begin
         if (full) begin
            for (int i = 0; i < PEND_DEPTH - 1; i++) begin
               pend_nxt[i] = pend[i+1];
            end
            pend_nxt[PEND_DEPTH-1] = data_byte;
         end else begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
               if (PC_W'(i) == pend_count) begin
                  pend_nxt[i] = data_byte;
               end
            end
            pend_count_nxt = pend_count + PC_W'(1);
         end
      end

      nxt.quote_mode   = qmode_n;
      nxt.fld_cnt      = count_mid;
      nxt.field_length = delim_end ? '0 : len_mid;
      nxt.truncated    = delim_end ? 1'b0 : trunc_mid;

      if (last_in_line) begin
         nxt.quote_mode   = QM_PLAIN;
         nxt.fld_cnt      = '0;
         nxt.field_length = '0;
         nxt.truncated    = 1'b0;
         pend_count_nxt   = '0;
      end
   end

endmodule

/* sv/cft_emit.sv */
// ----------------------------------------------------------------------------
// cft_emit
// Result register: holds one word's results and hands them out in order.
// ----------------------------------------------------------------------------
module cft_emit
   import cft_pkg::*;
#(
   parameter int PEND_DEPTH = PEND_DEPTH_DEF,
   localparam int M_W = $clog2(PEND_DEPTH + 2)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [PEND_DEPTH:0][7:0]  content,
   input  logic [M_W-1:0]            content_count,
   input  batch_meta_type            meta,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic [1:0]                rsp_kind,
   output logic [5:0]                rsp_field_index,
   output logic                      rsp_field_truncated,
   output logic                      rsp_too_many_fields,
   output logic                      rsp_last
);

   localparam int SEL_W = $clog2(PEND_DEPTH + 1);

   logic [PEND_DEPTH:0][7:0] content_ff, content_in;
   logic [M_W-1:0]           count_ff, count_in;
   logic [M_W-1:0]           ptr_ff, ptr_in;
   batch_meta_type           meta_ff, meta_in;
   logic                     in_content;
   logic                     end_a;
   logic                     end_b;
   logic                     final_one;
   logic                     take;

   always_comb begin
      in_content = ptr_ff < count_ff;
      end_a      = !in_content && meta_ff.end_field;
      end_b      = !in_content && !meta_ff.end_field && meta_ff.end_line;
      rsp_valid  = in_content || meta_ff.end_field || meta_ff.end_line;

      if (in_content) begin
         final_one = (ptr_ff + M_W'(1) == count_ff) &&
                     !meta_ff.end_field && !meta_ff.end_line;
      end else if (end_a) begin
         final_one = !meta_ff.end_line;
      end else begin
         final_one = end_b;
      end

      rsp_out_byte        = in_content ? content_ff[ptr_ff[SEL_W-1:0]] : '0;
      rsp_kind            = in_content ? KIND_DATA : (end_a ? KIND_END : KIND_LAST);
      rsp_field_index     = (in_content || end_a) ? meta_ff.index_a : meta_ff.index_b;
      rsp_too_many_fields = (in_content || end_a) ? meta_ff.many_a : meta_ff.many_b;
      rsp_field_truncated = in_content ? 1'b0 : (end_a ? meta_ff.trunc_a : meta_ff.trunc_b);
      rsp_last            = final_one;

      take = rsp_valid && !rsp_stall;
      free = !rsp_valid || (take && final_one);

      content_in = content_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      meta_in    = meta_ff;
      if (load) begin
         content_in = content;
         count_in   = content_count;
         ptr_in     = '0;
         meta_in    = meta;
      end else if (take) begin
         priority if (in_content) begin
            ptr_in = ptr_ff + M_W'(1);
         end else if (meta_ff.end_field) begin
            meta_in.end_field = 1'b0;
         end else begin
            meta_in.end_line = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      content_ff <= content_in;
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         meta_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         meta_ff  <= meta_in;
      end
   end

endmodule

/* sv/cft_checker.sv */
// ----------------------------------------------------------------------------
// cft_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module cft_checker
   import cft_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_kind,
   input logic [5:0]  rsp_field_index,
   input logic        rsp_field_truncated,
   input logic        rsp_too_many_fields,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_kind) && $stable(rsp_field_index) && $stable(rsp_last) &&
      $stable(rsp_field_truncated) && $stable(rsp_too_many_fields))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LAST |-> rsp_last)
      else $error("line end is not the final result of its word");

   a_content_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |-> !rsp_field_truncated)
      else $error("truncated flag on content word");

   a_new_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_LAST |=>
      !rsp_valid || rsp_field_index == '0)
      else $error("field index not restarted after line end");

endmodule

bind csv_field_tokenizer_core cft_checker u_cft_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for csv_field_tokenizer_core
// Feeds lines of bytes through the tokenizer and checks every result word
// against a cycle-free model of the tokenizer kept in the testbench. Covers
// quoting, doubled quotes, held CR/LF bytes, field truncation, the field
// count flag and unusual delimiter and quote settings, with random bursts on
// the request side and random stall patterns on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cft_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_APOS  = 8'h27;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [5:0] field_index;
      logic       field_truncated;
      logic       too_many_fields;
      logic       last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_in_line = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_kind;
   logic [5:0]  rsp_field_index;
   logic        rsp_field_truncated;
   logic        rsp_too_many_fields;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_DELIM;
   logic [13:0] csr_write_data = 14'd0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   csv_field_tokenizer_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_in_line    (req_last_in_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_kind            (rsp_kind),
      .rsp_field_index     (rsp_field_index),
      .rsp_field_truncated (rsp_field_truncated),
      .rsp_too_many_fields (rsp_too_many_fields),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // tokenizer model state
   logic [7:0]  m_delim;
   logic [7:0]  m_quote;
   logic [6:0]  m_fld_limit;
   logic [13:0] m_max_len;
   logic [1:0]  m_qmode;
   logic [6:0]  m_fcount;
   logic [13:0] m_flen;
   logic        m_trunc;
   logic [7:0]  m_held[PEND_DEPTH_DEF];
   int          m_held_n;

   token_type   token_q[$];
   token_type   step_buf[8];
   int          step_n;

   logic [7:0]  line_bytes[$];
   int          words_sent = 0;
   int          error_count = 0;
   int          burst_left = 0;

   function automatic void reset_model();
      m_delim      = DELIM_RST;
      m_quote      = QUOTE_RST;
      m_fld_limit  = MAX_FIELDS_RST;
      m_max_len    = MAX_LEN_RST;
      m_qmode      = QM_PLAIN;
      m_fcount     = 7'd0;
      m_flen       = 14'd0;
      m_trunc      = 1'b0;
      m_held_n     = 0;
   endfunction

   function automatic void add_token(logic [7:0] b, logic [1:0] k);
      token_type t;
      t.out_byte        = b;
      t.kind            = k;
      t.field_index     = (m_fcount > 7'd63) ? FIELD_IDX_MAX : m_fcount[5:0];
      t.field_truncated = (k != KIND_DATA) ? m_trunc : 1'b0;
      t.too_many_fields = (m_fcount >= m_fld_limit);
      t.last            = 1'b0;
      step_buf[step_n]  = t;
      step_n++;
   endfunction

   function automatic void put_content(logic [7:0] b);
      int limit;
      limit = (m_max_len == 14'd0) ? 0 : int'(m_max_len) - 1;
      if (int'(m_flen) < limit) begin
         add_token(b, KIND_DATA);
         m_flen++;
      end else begin
         m_trunc = 1'b1;
      end
   endfunction

   function automatic void flush_held();
      for (int i = 0; i < m_held_n; i++) put_content(m_held[i]);
      m_held_n = 0;
   endfunction

   function automatic void take_data(logic [7:0] b);
      if (b == BYTE_CR || b == BYTE_LF) begin
         if (m_held_n >= PEND_DEPTH_DEF) begin
            put_content(m_held[0]);
            for (int i = 1; i < PEND_DEPTH_DEF; i++) m_held[i-1] = m_held[i];
            m_held_n = PEND_DEPTH_DEF - 1;
         end
         m_held[m_held_n] = b;
         m_held_n++;
      end else begin
         flush_held();
         put_content(b);
      end
   endfunction

   function automatic void close_field(logic [1:0] k);
      add_token(8'h00, k);
      if (m_fcount < FIELD_CNT_MAX) m_fcount++;
      m_flen  = 14'd0;
      m_trunc = 1'b0;
   endfunction

   function automatic void tokenize_byte(logic [7:0] b, logic eol);
      logic      done;
      token_type t;
      step_n = 0;
      done   = 1'b0;
      if (m_qmode == QM_QSEEN) begin
         if (b == m_quote) begin
            take_data(m_quote);
            m_qmode = QM_QUOTED;
            done    = 1'b1;
         end else begin
            m_qmode = QM_PLAIN;
         end
      end
      if (!done) begin
         if (m_qmode == QM_QUOTED) begin
            if (b == m_quote) m_qmode = QM_QSEEN;
            else take_data(b);
         end else begin
            m_qmode = QM_PLAIN;
            if (b == m_quote) begin
               m_qmode = QM_QUOTED;
            end else if (b == m_delim) begin
               flush_held();
               close_field(KIND_END);
            end else begin
               take_data(b);
            end
         end
      end
      if (eol) begin
         m_held_n = 0;
         close_field(KIND_LAST);
         m_qmode  = QM_PLAIN;
         m_fcount = 7'd0;
         m_flen   = 14'd0;
         m_trunc  = 1'b0;
      end
      for (int i = 0; i < step_n; i++) begin
         t      = step_buf[i];
         t.last = (i == step_n - 1);
         token_q.push_back(t);
      end
   endfunction

   task automatic report_error(input string what, input int got, input int want);
      error_count++;
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : check_tokens
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            report_error("result word with nothing predicted", int'(rsp_kind), 0);
         end else begin
            want = token_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_error("out_byte", int'(rsp_out_byte), int'(want.out_byte));
            if (rsp_kind !== want.kind)
               report_error("kind", int'(rsp_kind), int'(want.kind));
            if (rsp_field_index !== want.field_index)
               report_error("field_index", int'(rsp_field_index),
                            int'(want.field_index));
            if (rsp_field_truncated !== want.field_truncated)
               report_error("field_truncated", int'(rsp_field_truncated),
                            int'(want.field_truncated));
            if (rsp_too_many_fields !== want.too_many_fields)
               report_error("too_many_fields", int'(rsp_too_many_fields),
                            int'(want.too_many_fields));
            if (rsp_last !== want.last)
               report_error("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   // response stall pattern, reshuffled whenever its random epoch runs out
   logic [15:0] stall_pat = 16'h0000;
   int          stall_pos = 0;
   int          stall_epoch = 0;

   always @(negedge clock) begin
      if (stall_epoch == 0) begin
         stall_epoch = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0: stall_pat = 16'h0000;
            1: stall_pat = 16'($urandom & $urandom);
            2: stall_pat = 16'($urandom);
            default: stall_pat = 16'($urandom | $urandom);
         endcase
         stall_pat[$urandom_range(0, 15)] = 1'b0;
      end
      stall_epoch--;
      rsp_stall <= reset ? 1'b0 : stall_pat[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eol);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data_byte    <= b;
      req_last_in_line <= eol;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tokenize_byte(b, eol);
      words_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_word(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   task automatic wait_drained(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DELIM:      m_delim     = data[7:0];
         CSR_QUOTE:      m_quote     = data[7:0];
         CSR_MAX_FIELDS: m_fld_limit = data[6:0];
         CSR_MAX_LEN:    m_max_len   = data;
      endcase
   endtask

   task automatic set_config(input logic [7:0] d, input logic [7:0] q,
                             input logic [6:0] mf, input logic [13:0] ml);
      wait_drained(SETTLE_CYCLES);
      write_reg(CSR_DELIM, {6'd0, d});
      write_reg(CSR_QUOTE, {6'd0, q});
      write_reg(CSR_MAX_FIELDS, {7'd0, mf});
      write_reg(CSR_MAX_LEN, ml);
   endtask

   function automatic logic [7:0] content_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5) return 8'h61 + 8'($urandom_range(0, 25));
      if (r <= 7) return $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_line();
      int nf;
      int n;
      int r;
      line_bytes.delete();
      nf = $urandom_range(1, 6);
      for (int f = 0; f < nf; f++) begin
         r = $urandom_range(0, 9);
         if (r >= 2 && r <= 5) begin
            n = $urandom_range(1, 8);
            repeat (n) line_bytes.push_back(content_byte());
         end else if (r >= 6) begin
            line_bytes.push_back(m_quote);
            n = $urandom_range(0, 6);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0: begin
                     line_bytes.push_back(m_quote);
                     line_bytes.push_back(m_quote);
                  end
                  1: line_bytes.push_back(m_delim);
                  default: line_bytes.push_back(content_byte());
               endcase
            end
            if ($urandom_range(0, 9) != 0) line_bytes.push_back(m_quote);
            if ($urandom_range(0, 9) == 0) line_bytes.push_back(content_byte());
         end
         if (f < nf - 1) line_bytes.push_back(m_delim);
      end
      if (line_bytes.size() == 0) line_bytes.push_back(content_byte());
      send_line();
   endtask

   task automatic noise_burst();
      int n;
      logic [7:0] b;
      n = $urandom_range(4, 20);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: b = m_quote;
            1: b = m_delim;
            2: b = BYTE_CR;
            3: b = BYTE_LF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_word(b, (i == n - 1) || ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic run_random_phase(input int budget);
      int start;
      start = words_sent;
      while (words_sent - start < budget) begin
         if ($urandom_range(0, 9) < 8) random_line();
         else noise_burst();
         if ($urandom_range(0, 11) == 0) wait_drained(0);
      end
   endtask

   task automatic test_basic_lines();
      // extremes of the byte, doubled quote, held CR/LF, delimiter as last byte
      line_bytes = {8'h00, 8'hFF, CH_COMMA, CH_DQUOTE, 8'h71, CH_DQUOTE, CH_DQUOTE,
                    BYTE_CR, BYTE_LF, CH_DQUOTE, CH_COMMA};
      send_line();
      // held buffer overflows, then released by content
      line_bytes = {8'h7A, BYTE_CR, BYTE_LF, BYTE_CR, BYTE_LF, BYTE_CR, 8'h77};
      send_line();
      // held bytes dropped at line end
      line_bytes = {8'h6B, BYTE_CR, BYTE_LF};
      send_line();
      // quotes still open at line end
      line_bytes = {CH_DQUOTE, 8'h6D};
      send_line();
      wait_drained(0);
   endtask

   task automatic test_equal_bytes();
      set_config(CH_COMMA, CH_COMMA, MAX_FIELDS_RST, MAX_LEN_RST);
      line_bytes = {CH_COMMA, 8'h61, CH_COMMA, CH_COMMA, 8'h62};
      send_line();
      set_config(BYTE_LF, BYTE_CR, 7'd1, 14'd2);
      line_bytes = {8'h61, 8'h62, BYTE_LF, BYTE_CR, 8'h78, BYTE_CR, BYTE_CR, BYTE_LF};
      send_line();
   endtask

   task automatic test_tiny_field_len();
      set_config(CH_COMMA, CH_DQUOTE, 7'd4, 14'd1);
      line_bytes = {8'h61, 8'h62, CH_COMMA, 8'h63};
      send_line();
      set_config(CH_COMMA, CH_DQUOTE, 7'd4, 14'd0);
      line_bytes = {8'h61, BYTE_CR, CH_COMMA, 8'h63};
      send_line();
   endtask

   task automatic test_wide_line();
      set_config(CH_COMMA, CH_DQUOTE, 7'd64, MAX_LEN_RST);
      line_bytes.delete();
      for (int i = 0; i < 70; i++) begin
         if (i % 10 == 0) line_bytes.push_back(8'h76);
         line_bytes.push_back(CH_COMMA);
      end
      line_bytes.push_back(8'h65);
      send_line();
   endtask

   task automatic test_random_settings();
      set_config(DELIM_RST, QUOTE_RST, MAX_FIELDS_RST, MAX_LEN_RST);
      run_random_phase(20);
      set_config(CH_SEMI, CH_APOS, 7'd3, 14'd4);
      run_random_phase(20);
      set_config(8'h00, 8'hFF, 7'd1, 14'd2);
      run_random_phase(20);
      set_config(8'hFF, 8'h00, 7'd64, 14'd8192);
      run_random_phase(20);
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 7'($urandom_range(1, 8)), 14'($urandom_range(2, 12)));
      run_random_phase(20);
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 7'($urandom_range(1, 64)), 14'($urandom_range(2, 40)));
      run_random_phase(20);
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_lines();
      test_equal_bytes();
      test_tiny_field_len();
      test_wide_line();
      test_random_settings();
      wait_drained(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/cft_pkg.sv
sv/cft_step.sv
sv/cft_emit.sv
sv/csv_field_tokenizer_core.sv
sv/cft_checker.sv
tb/sv/tb_top.sv
